// ===== rtl/lpef_pkg.sv =====
// Shared types and constants for the line peak edge finder.
`default_nettype none
package lpef_pkg;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned CNT_W     = 7;
	localparam int unsigned WIDE_W    = 40;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned PROD_W    = 38;
	localparam int unsigned DV_W      = 36;

	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_MIN_SPAN   = 3'd0;
	localparam cfg_idx_t REG_PEAK_THR   = 3'd1;
	localparam cfg_idx_t REG_NOISE      = 3'd2;
	localparam cfg_idx_t REG_RMS        = 3'd3;
	localparam cfg_idx_t REG_FLAT_SLOPE = 3'd4;

	typedef struct packed {
		logic [6:0]         min_span;
		logic signed [31:0] peak_threshold;
		logic signed [31:0] noise_level;
		logic [30:0]        rms_noise;
		logic [30:0]        flat_slope;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               bad;
		logic [31:0]        index;
	} a_word_t;

	typedef struct packed {
		logic used;
		logic edge_mark;
	} b_word_t;

	typedef struct packed {
		a_word_t a;
		b_word_t b;
		logic    last;
	} sample_t;

	typedef struct packed {
		logic [POS_W-1:0] rd_addr;
		logic             wr_a_en;
		logic [POS_W-1:0] wr_a_addr;
		a_word_t          wr_a;
		logic             wr_b_en;
		logic [POS_W-1:0] wr_b_addr;
		b_word_t          wr_b;
	} mem_req_t;

	typedef struct packed {
		logic             peak_found;
		logic [POS_W-1:0] lower_edge_pos;
		logic [POS_W-1:0] upper_edge_pos;
		logic [31:0]      lower_edge_mask;
		logic [31:0]      upper_edge_mask;
		logic [31:0]      peak_mask;
		logic             edges_marked;
		logic             peak_marked;
		logic             last_result;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_PICK, ST_UP_RD, ST_UP_EX, ST_DN_RD, ST_DN_EX,
		ST_DECIDE, ST_SWEEP, ST_CHECK, ST_PUSH, ST_FINISH
	} state_t;

	function automatic wide_t sx32(logic signed [31:0] v);
		return wide_t'(v);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/lpef_store.sv =====
// Line sample memories: sample data and per-sample used/edge flags.
`default_nettype none
module lpef_store #(
	parameter int LINE_LENGTH = 64
) (
	input  wire logic                clk,
	input  wire lpef_pkg::mem_req_t  req,
	output lpef_pkg::a_word_t        rd_a,
	output lpef_pkg::b_word_t        rd_b
);
	localparam int AW = $clog2(LINE_LENGTH);

	lpef_pkg::a_word_t mem_a [LINE_LENGTH];
	lpef_pkg::b_word_t mem_b [LINE_LENGTH];

	always_ff @(posedge clk) begin
		if (req.wr_a_en) begin
			mem_a[req.wr_a_addr[AW-1:0]] <= req.wr_a;
		end
		rd_a <= mem_a[req.rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (req.wr_b_en) begin
			mem_b[req.wr_b_addr[AW-1:0]] <= req.wr_b;
		end
		rd_b <= mem_b[req.rd_addr[AW-1:0]];
	end
endmodule
`default_nettype wire

// ===== rtl/lpef_ctrl.sv =====
// Sequencer: line load, peak scan, edge walks, used/edge sweep, result staging.
`default_nettype none
module lpef_ctrl #(
	parameter int LINE_LENGTH   = 64,
	parameter int GRADIENT_STEP = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lpef_pkg::cfg_t      cfg,
	input  wire logic                in_take,
	input  wire lpef_pkg::sample_t   in_smp,
	output logic                     busy,
	input  wire logic                can_emit,
	output logic                     emit,
	output lpef_pkg::result_t        emit_res,
	output lpef_pkg::mem_req_t       mem_req,
	input  wire lpef_pkg::a_word_t   rd_a,
	input  wire lpef_pkg::b_word_t   rd_b
);
	localparam int unsigned CW = lpef_pkg::CNT_W;
	localparam int unsigned PW = lpef_pkg::POS_W;
	localparam logic [CW-1:0] LINE_LEN_C = CW'(LINE_LENGTH);
	localparam logic [CW-1:0] GSTEP_C    = CW'(GRADIENT_STEP);
	localparam logic [4:0]    GSTEP5     = 5'(GRADIENT_STEP);

	lpef_pkg::state_t st_q, st_d;

	logic [CW-1:0]       load_cnt_q, n_q, cnt_q, dist_q;
	logic                v_s1;
	logic [PW-1:0]       pos_s1;
	logic                found_q;
	logic signed [31:0]  maxv_q, pmin_q;
	logic [PW-1:0]       mp_q, minp_q, iup_q, ilo_q;
	logic signed [7:0]   i_q;
	lpef_pkg::wide_t     lim_q;
	logic                lim_ok_q, vl_ok_q, vlast_lo_q, slope_q, hs_q;
	logic                up_ok_q, lo_ok_q, emark_q, pcand_q, hit_q;
	logic [lpef_pkg::PROD_W-1:0] prod_q;
	logic [lpef_pkg::DV_W-1:0]   dv_q;
	logic [31:0]         lo_idx_q, up_idx_q, pk_idx_q;
	logic                pend_v_q;
	lpef_pkg::result_t   pend_q, new_res;

	lpef_pkg::wide_t v_w;
	logic below, new_min, steep, over_lim, flat_run, near_stop, min_stop;
	logic up_dir, up_end, dn_end, emark_w, pcand_w;
	logic [CW-1:0] dist_w;
	logic [PW-1:0] span;
	logic signed [7:0] n_s;

	assign busy = (st_q != lpef_pkg::ST_IDLE);

	always_comb begin
		v_w      = lpef_pkg::sx32(rd_a.value);
		below    = rd_a.value < cfg.noise_level;
		new_min  = (v_w + lpef_pkg::wide_t'(dv_q)) < lpef_pkg::sx32(pmin_q);
		steep    = (lpef_pkg::sx32(pmin_q) - v_w) > lpef_pkg::wide_t'(prod_q);
		over_lim = lim_ok_q && (v_w > lim_q);
		flat_run = (dist_q > GSTEP_C) && slope_q;
		near_stop = rd_b.used || (!rd_a.bad && below && (!vl_ok_q || vlast_lo_q));
		min_stop  = !near_stop && !rd_a.bad && !new_min && (over_lim || flat_run);
		up_dir   = (st_q == lpef_pkg::ST_UP_RD) || (st_q == lpef_pkg::ST_UP_EX);
		n_s      = $signed({1'b0, n_q});
		up_end   = !(i_q < n_s);
		dn_end   = i_q[7];
		dist_w   = up_dir ? (i_q[CW-1:0] - {1'b0, minp_q}) : ({1'b0, minp_q} - i_q[CW-1:0]);
		span     = iup_q - ilo_q;
		emark_w  = (iup_q != mp_q) && (ilo_q != mp_q) && ({1'b0, span} >= cfg.min_span)
			&& up_ok_q && lo_ok_q;
		pcand_w  = emark_w && hs_q && slope_q && (maxv_q >= cfg.peak_threshold);

		new_res                 = '0;
		new_res.peak_found      = 1'b1;
		new_res.lower_edge_pos  = ilo_q;
		new_res.upper_edge_pos  = iup_q;
		new_res.lower_edge_mask = lo_idx_q;
		new_res.upper_edge_mask = up_idx_q;
		new_res.peak_mask       = pk_idx_q;
		new_res.edges_marked    = emark_q;
		new_res.peak_marked     = pcand_q && !hit_q;
	end

	// next state and memory/emit controls
	always_comb begin
		st_d     = st_q;
		emit     = 1'b0;
		emit_res = pend_q;
		mem_req  = '0;
		mem_req.wr_a_addr    = load_cnt_q[PW-1:0];
		mem_req.wr_a.value   = in_smp.a.value;
		mem_req.wr_a.bad     = in_smp.a.bad;
		mem_req.wr_a.index   = in_smp.a.index;
		mem_req.wr_b_addr    = load_cnt_q[PW-1:0];
		mem_req.wr_b         = in_smp.b;
		case (st_q)
			lpef_pkg::ST_IDLE: begin
				if (in_take) begin
					mem_req.wr_a_en = (load_cnt_q < LINE_LEN_C);
					mem_req.wr_b_en = (load_cnt_q < LINE_LEN_C);
					if (in_smp.last) begin
						st_d = lpef_pkg::ST_SCAN;
					end
				end
			end
			lpef_pkg::ST_SCAN, lpef_pkg::ST_CHECK: begin
				mem_req.rd_addr = cnt_q[PW-1:0];
				if (cnt_q >= n_q && !v_s1) begin
					st_d = (st_q == lpef_pkg::ST_SCAN) ? lpef_pkg::ST_PICK : lpef_pkg::ST_PUSH;
				end
			end
			lpef_pkg::ST_PICK: begin
				if (!found_q || maxv_q < cfg.noise_level) begin
					st_d = lpef_pkg::ST_FINISH;
				end else begin
					st_d = lpef_pkg::ST_UP_RD;
				end
			end
			lpef_pkg::ST_UP_RD: begin
				mem_req.rd_addr = i_q[PW-1:0];
				st_d = up_end ? lpef_pkg::ST_DN_RD : lpef_pkg::ST_UP_EX;
			end
			lpef_pkg::ST_UP_EX: begin
				st_d = (near_stop || min_stop) ? lpef_pkg::ST_DN_RD : lpef_pkg::ST_UP_RD;
			end
			lpef_pkg::ST_DN_RD: begin
				mem_req.rd_addr = i_q[PW-1:0];
				st_d = dn_end ? lpef_pkg::ST_DECIDE : lpef_pkg::ST_DN_EX;
			end
			lpef_pkg::ST_DN_EX: begin
				st_d = (near_stop || min_stop) ? lpef_pkg::ST_DECIDE : lpef_pkg::ST_DN_RD;
			end
			lpef_pkg::ST_DECIDE: begin
				st_d = lpef_pkg::ST_SWEEP;
			end
			lpef_pkg::ST_SWEEP: begin
				mem_req.rd_addr        = cnt_q[PW-1:0];
				mem_req.wr_b_en        = v_s1;
				mem_req.wr_b_addr      = pos_s1;
				mem_req.wr_b.used      = 1'b1;
				mem_req.wr_b.edge_mark = rd_b.edge_mark
					|| (emark_q && (pos_s1 == ilo_q || pos_s1 == iup_q));
				if (cnt_q > {1'b0, iup_q} && !v_s1) begin
					st_d = pcand_q ? lpef_pkg::ST_CHECK : lpef_pkg::ST_PUSH;
				end
			end
			lpef_pkg::ST_PUSH: begin
				if (!pend_v_q) begin
					st_d = lpef_pkg::ST_SCAN;
				end else if (can_emit) begin
					emit = 1'b1;
					st_d = lpef_pkg::ST_SCAN;
				end
			end
			lpef_pkg::ST_FINISH: begin
				if (can_emit) begin
					emit = 1'b1;
					if (pend_v_q) begin
						emit_res.last_result = 1'b1;
					end else begin
						emit_res = '0;
						emit_res.last_result = 1'b1;
					end
					st_d = lpef_pkg::ST_IDLE;
				end
			end
			default: st_d = lpef_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lpef_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			pend_v_q   <= 1'b0;
			v_s1       <= 1'b0;
		end else begin
			case (st_q)
				lpef_pkg::ST_IDLE: begin
					if (in_take && load_cnt_q < LINE_LEN_C) begin
						load_cnt_q <= load_cnt_q + 1'b1;
					end
				end
				lpef_pkg::ST_PUSH: begin
					if (!pend_v_q || can_emit) begin
						pend_v_q <= 1'b1;
					end
				end
				lpef_pkg::ST_FINISH: begin
					if (can_emit) begin
						pend_v_q   <= 1'b0;
						load_cnt_q <= '0;
					end
				end
				default: ;
			endcase
			if (st_q == lpef_pkg::ST_SCAN || st_q == lpef_pkg::ST_CHECK) begin
				v_s1 <= (cnt_q < n_q);
			end else if (st_q == lpef_pkg::ST_SWEEP) begin
				v_s1 <= (cnt_q <= {1'b0, iup_q});
			end else begin
				v_s1 <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		pos_s1 <= cnt_q[PW-1:0];
		case (st_q)
			lpef_pkg::ST_IDLE: begin
				if (in_take) begin
					n_q     <= (load_cnt_q < LINE_LEN_C) ? load_cnt_q + 1'b1 : load_cnt_q;
					dv_q    <= lpef_pkg::DV_W'(cfg.flat_slope) * lpef_pkg::DV_W'(GSTEP5);
					cnt_q   <= '0;
					found_q <= 1'b0;
				end
			end
			lpef_pkg::ST_SCAN: begin
				if (cnt_q < n_q) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (v_s1 && !rd_a.bad && !rd_b.used && (!found_q || rd_a.value > maxv_q)) begin
					maxv_q  <= rd_a.value;
					mp_q    <= pos_s1;
					found_q <= 1'b1;
				end
			end
			lpef_pkg::ST_PICK: begin
				i_q      <= $signed({2'b00, mp_q}) + 8'sd1;
				pmin_q   <= maxv_q;
				minp_q   <= mp_q;
				vl_ok_q  <= 1'b0;
				lim_ok_q <= 1'b0;
				slope_q  <= 1'b0;
			end
			lpef_pkg::ST_UP_RD, lpef_pkg::ST_DN_RD: begin
				dist_q <= dist_w;
				prod_q <= lpef_pkg::PROD_W'(cfg.flat_slope) * lpef_pkg::PROD_W'(dist_w);
				if (st_q == lpef_pkg::ST_UP_RD && up_end) begin
					iup_q    <= PW'(n_q - 1'b1);
					up_ok_q  <= 1'b0;
					hs_q     <= slope_q;
					i_q      <= $signed({2'b00, mp_q}) - 8'sd1;
					pmin_q   <= maxv_q;
					minp_q   <= mp_q;
					vl_ok_q  <= 1'b0;
					lim_ok_q <= 1'b0;
					slope_q  <= 1'b0;
				end
				if (st_q == lpef_pkg::ST_DN_RD && dn_end) begin
					ilo_q   <= '0;
					lo_ok_q <= 1'b0;
				end
			end
			lpef_pkg::ST_UP_EX, lpef_pkg::ST_DN_EX: begin
				if (near_stop || min_stop) begin
					if (up_dir) begin
						iup_q    <= near_stop ? PW'(i_q - 8'sd1) : minp_q;
						up_ok_q  <= 1'b1;
						hs_q     <= slope_q;
						i_q      <= $signed({2'b00, mp_q}) - 8'sd1;
						pmin_q   <= maxv_q;
						minp_q   <= mp_q;
						vl_ok_q  <= 1'b0;
						lim_ok_q <= 1'b0;
						slope_q  <= 1'b0;
					end else begin
						ilo_q   <= near_stop ? PW'(i_q + 8'sd1) : minp_q;
						lo_ok_q <= 1'b1;
					end
				end else begin
					// advance one sample; bad samples leave the walk history alone
					i_q <= up_dir ? i_q + 8'sd1 : i_q - 8'sd1;
					if (!rd_a.bad) begin
						if (new_min) begin
							if (!slope_q) begin
								slope_q <= steep;
							end
							pmin_q   <= rd_a.value;
							minp_q   <= i_q[PW-1:0];
							lim_q    <= v_w + lpef_pkg::wide_t'({rd_a.value[0] & 1'b0,
								cfg.rms_noise, 1'b0});
							lim_ok_q <= 1'b1;
						end
						vlast_lo_q <= below;
						vl_ok_q    <= 1'b1;
					end
				end
			end
			lpef_pkg::ST_DECIDE: begin
				emark_q <= emark_w;
				pcand_q <= pcand_w;
				hit_q   <= 1'b0;
				cnt_q   <= {1'b0, ilo_q};
			end
			lpef_pkg::ST_SWEEP: begin
				if (cnt_q <= {1'b0, iup_q}) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (v_s1) begin
					if (pos_s1 == ilo_q) lo_idx_q <= rd_a.index;
					if (pos_s1 == iup_q) up_idx_q <= rd_a.index;
					if (pos_s1 == mp_q)  pk_idx_q <= rd_a.index;
				end
				if (cnt_q > {1'b0, iup_q} && !v_s1) begin
					cnt_q <= '0;
				end
			end
			lpef_pkg::ST_CHECK: begin
				if (cnt_q < n_q) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (v_s1 && rd_b.edge_mark && rd_a.index == pk_idx_q) begin
					hit_q <= 1'b1;
				end
			end
			lpef_pkg::ST_PUSH: begin
				if (!pend_v_q || can_emit) begin
					pend_q  <= new_res;
					cnt_q   <= '0;
					found_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lpef_pkg::ST_FINISH && can_emit) |=> (load_cnt_q == '0))
		else $error("line count not cleared after final result");
	a_flag_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_b_en |-> (st_q == lpef_pkg::ST_SWEEP || st_q == lpef_pkg::ST_IDLE))
		else $error("flag memory written outside load or sweep");
	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lpef_pkg::ST_DECIDE) |-> (ilo_q <= mp_q && mp_q <= iup_q))
		else $error("edges do not bracket the peak");
	a_idle_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lpef_pkg::ST_IDLE) |-> !pend_v_q)
		else $error("staged result left behind at idle");
endmodule
`default_nettype wire

// ===== rtl/line_peak_edge_finder.sv =====
// Top level of the line peak edge finder: ports, config registers, output register.
// Samples of a line load at one beat per cycle while idle into a sample memory
// and a flag memory (one read port each, registered read). The beat flagged
// last_sample starts processing and stalls the input until the line is done.
// For each peak the sequencer scans the n stored samples for the highest unused
// good one, walks up and down from it with a memory read, then an evaluate step,
// per visited sample, sweeps the span between the edges to set used and edge
// flags, and when a peak mark is a candidate scans the line once more for an
// edge mark at the peak's mask index.
// Each result is held one peak back so that the final one can carry
// last_result; a line with no peak gives one result with peak_found low.
// Results leave through a single output register; config writes are always
// ready and are to be issued only while the block is idle.
`default_nettype none
module line_peak_edge_finder #(
	parameter int LINE_LENGTH   = 64,
	parameter int GRADIENT_STEP = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic signed [31:0] sample_value,
	input  wire logic        sample_bad,
	input  wire logic [31:0] mask_index,
	input  wire logic        already_used,
	input  wire logic        prior_edge,
	input  wire logic        last_sample,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             peak_found,
	output logic [5:0]       lower_edge_pos,
	output logic [5:0]       upper_edge_pos,
	output logic [31:0]      lower_edge_mask,
	output logic [31:0]      upper_edge_mask,
	output logic [31:0]      peak_mask,
	output logic             edges_marked,
	output logic             peak_marked,
	output logic             last_result
);
	lpef_pkg::cfg_t     cfg_q;
	lpef_pkg::sample_t  smp;
	lpef_pkg::mem_req_t mem_req;
	lpef_pkg::a_word_t  rd_a;
	lpef_pkg::b_word_t  rd_b;
	lpef_pkg::result_t  emit_res, out_q;
	logic busy, emit, in_take, can_emit, out_valid_q;

	assign cfg_ready = 1'b1;

	// config registers; writes past the register list drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_span       <= 7'd3;
			cfg_q.peak_threshold <= '0;
			cfg_q.noise_level    <= '0;
			cfg_q.rms_noise      <= '0;
			cfg_q.flat_slope     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lpef_pkg::REG_MIN_SPAN:   cfg_q.min_span       <= cfg_data[6:0];
				lpef_pkg::REG_PEAK_THR:   cfg_q.peak_threshold <= $signed(cfg_data);
				lpef_pkg::REG_NOISE:      cfg_q.noise_level    <= $signed(cfg_data);
				lpef_pkg::REG_RMS:        cfg_q.rms_noise      <= cfg_data[30:0];
				lpef_pkg::REG_FLAT_SLOPE: cfg_q.flat_slope     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// hold input while a line is in processing
	assign in_stall = busy;
	assign in_take  = in_valid && !in_stall;

	assign smp.a.value     = sample_value;
	assign smp.a.bad       = sample_bad;
	assign smp.a.index     = mask_index;
	assign smp.b.used      = already_used;
	assign smp.b.edge_mark = prior_edge;
	assign smp.last        = last_sample;

	// output register frees when the waiting beat is taken
	assign can_emit = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_res;
		end
	end

	assign out_valid       = out_valid_q;
	assign peak_found      = out_q.peak_found;
	assign lower_edge_pos  = out_q.lower_edge_pos;
	assign upper_edge_pos  = out_q.upper_edge_pos;
	assign lower_edge_mask = out_q.lower_edge_mask;
	assign upper_edge_mask = out_q.upper_edge_mask;
	assign peak_mask       = out_q.peak_mask;
	assign edges_marked    = out_q.edges_marked;
	assign peak_marked     = out_q.peak_marked;
	assign last_result     = out_q.last_result;

	lpef_store #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_store (
		.clk  (clk),
		.req  (mem_req),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	lpef_ctrl #(
		.LINE_LENGTH  (LINE_LENGTH),
		.GRADIENT_STEP(GRADIENT_STEP)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_take (in_take),
		.in_smp  (smp),
		.busy    (busy),
		.can_emit(can_emit),
		.emit    (emit),
		.emit_res(emit_res),
		.mem_req (mem_req),
		.rd_a    (rd_a),
		.rd_b    (rd_b)
	);
endmodule
`default_nettype wire
